[hdl/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg
// shared widths, root kind codes and the beat types handed along the cell rows
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_WIDTH  = 16;
  localparam int ROOT_WIDTH  = COEF_WIDTH + 1;
  // discriminant magnitude, below 2^(2*COEF_WIDTH+1)
  localparam int DISC_WIDTH  = 2 * COEF_WIDTH + 2;
  // integer square root bits, one sqrt cell per bit
  localparam int SQRT_BITS   = COEF_WIDTH + 1;
  localparam int SQRT_IDX_W  = $clog2(SQRT_BITS);
  // numerator magnitude bits, one divider cell per quotient bit
  localparam int NUM_WIDTH   = SQRT_BITS + 1;
  // divisor magnitude |2a|
  localparam int DIV_WIDTH   = COEF_WIDTH + 1;

  localparam logic [1:0] KIND_NONE      = 2'd0;
  localparam logic [1:0] KIND_DOUBLE    = 2'd1;
  localparam logic [1:0] KIND_TWO       = 2'd2;
  localparam logic [1:0] KIND_LEAD_ZERO = 2'd3;

  typedef struct packed {
    logic                          vld;
    logic [1:0]                    kind;
    logic signed [COEF_WIDTH-1:0]  b;
    logic signed [DIV_WIDTH-1:0]   d2;
    logic [DISC_WIDTH-1:0]         rem;
    logic [SQRT_BITS-1:0]          root;
  } sq_t;

  typedef struct packed {
    logic                  vld;
    logic [1:0]            kind;
    logic [DIV_WIDTH-1:0]  dmag;
    logic                  neg1;
    logic                  neg2;
    logic [NUM_WIDTH-1:0]  num1;
    logic [NUM_WIDTH-1:0]  num2;
    logic [DIV_WIDTH-1:0]  rem1;
    logic [DIV_WIDTH-1:0]  rem2;
  } dv_t;

endpackage

[hdl/qrs_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// one bit of the integer square root, remainder form, registered
// ----------------------------------------------------------------------------
module qrs_sqrt_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [qrs_pkg::SQRT_IDX_W-1:0]    bit_i,
  input  qrs_pkg::sq_t                      cell_i,
  output qrs_pkg::sq_t                      cell_o
);

  logic [qrs_pkg::DISC_WIDTH-1:0] cand;
  logic                           take;
  qrs_pkg::sq_t                   cell_d, cell_q;

  // (2*root + 2^bit) * 2^bit
  assign cand = (qrs_pkg::DISC_WIDTH'(cell_i.root) << (bit_i + qrs_pkg::SQRT_IDX_W'(1)))
              | (qrs_pkg::DISC_WIDTH'(1) << {bit_i, 1'b0});
  assign take = cell_i.rem >= cand;

  always_comb begin
    cell_d = cell_i;
    if (take) begin
      cell_d.rem  = cell_i.rem - cand;
      cell_d.root = cell_i.root | (qrs_pkg::SQRT_BITS'(1) << bit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

[hdl/qrs_div_cell.sv]
// ----------------------------------------------------------------------------
// qrs_div_cell
// one restoring division step for both root lanes, registered
// ----------------------------------------------------------------------------
module qrs_div_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  qrs_pkg::dv_t cell_i,
  output qrs_pkg::dv_t cell_o
);

  logic [qrs_pkg::DIV_WIDTH:0] part1, part2, dext;
  logic                        ge1, ge2;
  qrs_pkg::dv_t                cell_d, cell_q;

  assign dext  = {1'b0, cell_i.dmag};
  assign part1 = {cell_i.rem1, cell_i.num1[qrs_pkg::NUM_WIDTH-1]};
  assign part2 = {cell_i.rem2, cell_i.num2[qrs_pkg::NUM_WIDTH-1]};
  assign ge1   = part1 >= dext;
  assign ge2   = part2 >= dext;

  always_comb begin
    logic [qrs_pkg::DIV_WIDTH:0] r1, r2;
    r1 = ge1 ? part1 - dext : part1;
    r2 = ge2 ? part2 - dext : part2;
    cell_d      = cell_i;
    // quotient bits fill in from the bottom as numerator bits leave the top
    cell_d.num1 = {cell_i.num1[qrs_pkg::NUM_WIDTH-2:0], ge1};
    cell_d.num2 = {cell_i.num2[qrs_pkg::NUM_WIDTH-2:0], ge2};
    cell_d.rem1 = r1[qrs_pkg::DIV_WIDTH-1:0];
    cell_d.rem2 = r2[qrs_pkg::DIV_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

[hdl/quadratic_root_solver.sv]
// ----------------------------------------------------------------------------
// quadratic_root_solver
// real roots of a*x^2 + b*x + c, truncated toward zero, one beat per unstalled cycle
// ----------------------------------------------------------------------------
// stages from input beat to output beat: product stage, discriminant stage,
//   17 sqrt cells, numerator stage, 18 divider cells, output register
// throughput: one beat per cycle unless the output stalls, set by the rows
//   of one-bit cells; empty stages close up on a stall
// reset: rst_ni clears every stage valid bit and the output valid
// ----------------------------------------------------------------------------
module quadratic_root_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beat
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // coef_a [15:0], coef_b [31:16], coef_c [47:32]
  // output beat
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // root_one [16:0], root_two [33:17], zero fill
  output logic [1:0]  m_axis_tuser    // root_kind [1:0]
);

  localparam int CW     = qrs_pkg::COEF_WIDTH;
  localparam int NSQ    = qrs_pkg::SQRT_BITS;
  localparam int NDV    = qrs_pkg::NUM_WIDTH;
  localparam int NW     = qrs_pkg::NUM_WIDTH + 1;  // signed numerator
  localparam int RW     = qrs_pkg::ROOT_WIDTH;
  localparam int DW     = qrs_pkg::DISC_WIDTH + 1; // signed discriminant
  // stage order: products, discriminant, sqrt row, numerator, divider row
  localparam int ST_P   = 0;
  localparam int ST_D   = 1;
  localparam int ST_SQ  = 2;
  localparam int ST_N   = ST_SQ + NSQ;
  localparam int ST_DV  = ST_N + 1;
  localparam int NST    = ST_DV + NDV;

  logic [NST-1:0] stg_vld;
  logic [NST:0]   stg_en;     // stg_en[NST] is the output register

  // a stage loads when it is empty or its successor loads
  assign stg_en[NST] = !m_axis_tvalid || m_axis_tready;
  for (genvar i = 0; i < NST; i++) begin : g_en
    assign stg_en[i] = !stg_vld[i] || stg_en[i+1];
  end
  assign s_axis_tready = stg_en[ST_P];

  // ---------------------------------------------------------------- products
  logic signed [CW-1:0]   in_a, in_b, in_c;
  logic                   p_vld_q;
  logic signed [CW-1:0]   p_a_q, p_b_q;
  logic signed [2*CW-1:0] p_bb_q, p_ac_q;

  assign in_a = s_axis_tdata[CW-1:0];
  assign in_b = s_axis_tdata[2*CW-1:CW];
  assign in_c = s_axis_tdata[3*CW-1:2*CW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (stg_en[ST_P]) begin
      p_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[ST_P]) begin
      p_a_q  <= in_a;
      p_b_q  <= in_b;
      p_bb_q <= in_b * in_b;
      p_ac_q <= in_a * in_c;
    end
  end
  assign stg_vld[ST_P] = p_vld_q;

  // ------------------------------------------------------------ discriminant
  logic signed [DW-1:0] disc;
  qrs_pkg::sq_t         d_d, d_q;

  assign disc = DW'(p_bb_q) - (DW'(p_ac_q) <<< 2);

  always_comb begin
    d_d      = '0;
    d_d.vld  = p_vld_q;
    d_d.b    = p_b_q;
    d_d.d2   = {p_a_q, 1'b0};
    priority if (p_a_q == '0) begin
      d_d.kind = qrs_pkg::KIND_LEAD_ZERO;
    end else if (disc < 0) begin
      d_d.kind = qrs_pkg::KIND_NONE;
    end else if (disc == '0) begin
      d_d.kind = qrs_pkg::KIND_DOUBLE;
    end else begin
      d_d.kind = qrs_pkg::KIND_TWO;
      d_d.rem  = disc[qrs_pkg::DISC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q <= '0;
    end else if (stg_en[ST_D]) begin
      d_q <= d_d;
    end
  end
  assign stg_vld[ST_D] = d_q.vld;

  // ---------------------------------------------------------------- sqrt row
  // cell k settles root bit NSQ-1-k; remainder ends at disc - root^2
  qrs_pkg::sq_t sq_c [NSQ+1];
  assign sq_c[0] = d_q;

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (stg_en[ST_SQ+k]),
      .bit_i  (qrs_pkg::SQRT_IDX_W'(NSQ-1-k)),
      .cell_i (sq_c[k]),
      .cell_o (sq_c[k+1])
    );
    assign stg_vld[ST_SQ+k] = sq_c[k+1].vld;
  end

  // --------------------------------------------------------------- numerators
  // an inexact root sits strictly between s and s+1, so each quotient is of a
  // value just above an integer numerator; fold signs into a magnitude divide
  function automatic logic [NDV:0] num_prep(input logic signed [NW-1:0] n,
                                            input logic exact,
                                            input logic dneg);
    logic [NW-1:0] m;
    logic [NW-1:0] u;
    logic          neg;
    if (exact) begin
      neg = n[NW-1] ^ dneg;
      u   = n[NW-1] ? -n : n;
    end else begin
      m   = dneg ? ~n : n;
      neg = m[NW-1];
      u   = m[NW-1] ? ~m : m;
    end
    return {neg, u[NDV-1:0]};
  endfunction

  qrs_pkg::sq_t          sq_end;
  logic                  exact;
  logic signed [NW-1:0]  negb, n1, n2;
  logic [NDV:0]          pre1, pre2;
  qrs_pkg::dv_t          n_d, n_q;

  assign sq_end = sq_c[NSQ];
  assign exact  = sq_end.rem == '0;
  assign negb   = -NW'(sq_end.b);
  assign n1     = negb + NW'(sq_end.root);
  assign n2     = negb - NW'(sq_end.root) - NW'(!exact);
  assign pre1   = num_prep(n1, exact, sq_end.d2[qrs_pkg::DIV_WIDTH-1]);
  assign pre2   = num_prep(n2, exact, sq_end.d2[qrs_pkg::DIV_WIDTH-1]);

  always_comb begin
    n_d      = '0;
    n_d.vld  = sq_end.vld;
    n_d.kind = sq_end.kind;
    n_d.dmag = sq_end.d2[qrs_pkg::DIV_WIDTH-1] ? -sq_end.d2 : sq_end.d2;
    n_d.neg1 = pre1[NDV];
    n_d.neg2 = pre2[NDV];
    n_d.num1 = pre1[NDV-1:0];
    n_d.num2 = pre2[NDV-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (stg_en[ST_N]) begin
      n_q <= n_d;
    end
  end
  assign stg_vld[ST_N] = n_q.vld;

  // ------------------------------------------------------------- divider row
  qrs_pkg::dv_t dv_c [NDV+1];
  assign dv_c[0] = n_q;

  for (genvar k = 0; k < NDV; k++) begin : g_dv
    qrs_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (stg_en[ST_DV+k]),
      .cell_i (dv_c[k]),
      .cell_o (dv_c[k+1])
    );
    assign stg_vld[ST_DV+k] = dv_c[k+1].vld;
  end

  // ------------------------------------------------------------ output stage
  // apply sign and clamp to the root range
  function automatic logic [RW-1:0] root_fix(input logic [NDV-1:0] q, input logic neg);
    logic [RW-1:0] r;
    if (neg) begin
      r = (q > NDV'(1 << (RW-1))) ? RW'(1 << (RW-1)) : -q[RW-1:0];
    end else begin
      r = (q > NDV'((1 << (RW-1)) - 1)) ? RW'((1 << (RW-1)) - 1) : q[RW-1:0];
    end
    return r;
  endfunction

  qrs_pkg::dv_t  dv_end;
  logic          has_root;
  logic [RW-1:0] r1_q, r2_q;
  logic [1:0]    kind_q;
  logic          out_vld_q;

  assign dv_end   = dv_c[NDV];
  assign has_root = (dv_end.kind == qrs_pkg::KIND_TWO) || (dv_end.kind == qrs_pkg::KIND_DOUBLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (stg_en[NST]) begin
      out_vld_q <= dv_end.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[NST]) begin
      kind_q <= dv_end.kind;
      r1_q   <= has_root ? root_fix(dv_end.num1, dv_end.neg1) : '0;
      r2_q   <= has_root ? root_fix(dv_end.num2, dv_end.neg2) : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {6'd0, r2_q, r1_q};

`ifndef SYNTHESIS
  // input side only backs up when every stage is full and the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while pipeline has room");

  // zero leading coefficient and no-root beats carry zero roots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == qrs_pkg::KIND_LEAD_ZERO ||
                       m_axis_tuser == qrs_pkg::KIND_NONE))
    |-> (m_axis_tdata == '0))
    else $error("nonzero roots without real roots");

  // double root gives the same value on both branches
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == qrs_pkg::KIND_DOUBLE)
    |-> (m_axis_tdata[16:0] == m_axis_tdata[33:17]))
    else $error("double root branches differ");
`endif

endmodule
